// File: rtl/dtsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtsg_pkg;

	// field and register widths
	localparam int RATE_W   = 18;
	localparam int FREQ_W   = 17;
	localparam int SAMPLE_W = 14;
	localparam int TAB_W    = 13;

	// step counter of the serial divider, holds up to RATE_W
	localparam int CNT_W = 5;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

	// pi/2 in Q2.62
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	// sine at multiples of 30 degrees, scaled by 2048
	localparam logic signed [TAB_W-1:0] EXACT_TWELFTHS [12] = '{
		13'sd0, 13'sd1024, 13'sd1773, 13'sd2048, 13'sd1773, 13'sd1024,
		13'sd0, -13'sd1024, -13'sd1773, -13'sd2048, -13'sd1773, -13'sd1024
	};

	// request from the top level to one phase lane
	typedef struct packed {
		logic start;
		logic clear;
		logic run;
	} lane_cmd_t;

	// request from a lane to its serial divider
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
	} div_cmd_t;

endpackage

`default_nettype wire

// File: rtl/dual_tone_sine_generator_core.sv
// Dual-tone sine generator. Each accepted request is one sample tick carrying two tone
// frequencies in Hz and a segment_start flag that restarts both phases at zero. Two
// phase accumulators count exactly modulo the rate in rate_hz; each tone picks the sine
// table entry floor(phase * SINE_ENTRIES / rate) of trunc(2048 * sin), and sample is
// the sum of the two entries (scale by 2^-11 for float audio). A zero rate gives
// silence. After reset the block copies the table into its RAM and takes no request
// until the copy is done; rate writes are taken at any time. Both
// tones run in parallel, each on a bit-serial divider that retires one quotient bit per
// cycle. A phase that is not below a newly lowered rate needs an extra division to
// reduce it first, and a frequency at or above the rate an extra division as well; with
// a zero rate a request skips the dividers.
// The next request is taken while a finished sample still waits at the output.
`timescale 1ns / 1ps
`default_nettype none

module dual_tone_sine_generator_core #(
	parameter int SINE_ENTRIES = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [dtsg_pkg::RATE_W-1:0]  rate_hz,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic        [dtsg_pkg::FREQ_W-1:0]  first_frequency,
	input  wire logic        [dtsg_pkg::FREQ_W-1:0]  second_frequency,
	input  wire logic                                segment_start,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [dtsg_pkg::SAMPLE_W-1:0] sample
);

	import dtsg_pkg::*;

	localparam int          IDX_W     = $clog2(SINE_ENTRIES);
	localparam logic [63:0] ENTRIES_W = 64'(SINE_ENTRIES);

	typedef logic signed [TAB_W-1:0] sine_rom_t [SINE_ENTRIES];

	typedef enum logic [2:0] {
		S_FILL,
		S_IDLE,
		S_WAIT,
		S_RD1,
		S_RD2,
		S_OUT
	} state_t;

	// (a * b) >> 62 for Q2.62 operands
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] pr;
		pr = {64'd0, a} * {64'd0, b};
		return pr[125:62];
	endfunction

	// taylor term divided by (2i)(2i+1)
	function automatic logic [63:0] div_term(input logic [63:0] term, input int i);
		case (i)
			1:  return term / 64'd6;
			2:  return term / 64'd20;
			3:  return term / 64'd42;
			4:  return term / 64'd72;
			5:  return term / 64'd110;
			6:  return term / 64'd156;
			7:  return term / 64'd210;
			8:  return term / 64'd272;
			9:  return term / 64'd342;
			10: return term / 64'd420;
			11: return term / 64'd506;
			12: return term / 64'd600;
			13: return term / 64'd702;
			14: return term / 64'd812;
			15: return term / 64'd930;
			16: return term / 64'd1056;
			17: return term / 64'd1190;
			18: return term / 64'd1332;
			19: return term / 64'd1482;
			20: return term / 64'd1640;
			default: return term;
		endcase
	endfunction

	// one table entry: exact at multiples of 30 degrees, else a Q2.62 series
	function automatic logic signed [TAB_W-1:0] sine_entry(input logic [63:0] k);
		logic [63:0]              twelve;
		logic [63:0]              p;
		logic [63:0]              q;
		logic [63:0]              rem;
		logic [63:0]              x;
		logic [63:0]              x2;
		logic [63:0]              term;
		logic [63:0]              sum;
		logic [3:0]               tw;
		logic signed [TAB_W-1:0]  mag;
		twelve = k * 64'd12;
		if ((twelve % ENTRIES_W) == 64'd0) begin
			tw = 4'((twelve / ENTRIES_W) % 64'd12);
			return EXACT_TWELFTHS[tw];
		end
		p   = k * 64'd4;
		q   = p / ENTRIES_W;
		rem = p % ENTRIES_W;
		if (q[0]) begin
			rem = ENTRIES_W - rem;
		end
		x    = (HALF_PI_Q62 / ENTRIES_W) * rem + ((HALF_PI_Q62 % ENTRIES_W) * rem) / ENTRIES_W;
		x2   = mul_q62(x, x);
		term = x;
		sum  = x;
		for (int i = 1; i <= 20; i++) begin
			term = div_term(mul_q62(term, x2), i);
			if (i % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		mag = TAB_W'(sum >> 51);
		return (q >= 64'd2) ? -mag : mag;
	endfunction

	function automatic sine_rom_t build_table();
		sine_rom_t t;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			t[k] = sine_entry(64'(k));
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_TABLE = build_table();

	state_t                     state_q;
	logic [RATE_W-1:0]          rate_q;
	logic                       run_q;
	logic [IDX_W-1:0]           fill_q;
	logic signed [TAB_W-1:0]    t1_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       out_valid_q;
	logic                       out_load;

	lane_cmd_t                  lane_cmd;
	logic                       idle1;
	logic                       idle2;
	logic [IDX_W-1:0]           idx1;
	logic [IDX_W-1:0]           idx2;

	logic                       ram_we;
	logic [IDX_W-1:0]           ram_raddr;
	logic [TAB_W-1:0]           ram_rdata;
	logic signed [TAB_W-1:0]    tab_rd;
	logic                       accept;

	// sample rate register, writable at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= rate_hz;
		end
	end

	// request handshake and lane start
	assign accept         = (state_q == S_IDLE) && in_valid;
	assign in_stall       = state_q != S_IDLE;
	assign lane_cmd.start = accept;
	assign lane_cmd.clear = segment_start;
	assign lane_cmd.run   = rate_q != '0;

	dtsg_lane #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lane_cmd),
		.freq   (first_frequency),
		.rate   (rate_q),
		.idle   (idle1),
		.idx    (idx1)
	);

	dtsg_lane #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_lane2 (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lane_cmd),
		.freq   (second_frequency),
		.rate   (rate_q),
		.idle   (idle2),
		.idx    (idx2)
	);

	// sine table RAM, filled once after reset, then read for both tones in turn
	assign ram_we    = state_q == S_FILL;
	assign ram_raddr = (state_q == S_WAIT) ? idx1 : idx2;
	assign tab_rd    = $signed(ram_rdata);

	dtsg_ram #(
		.WIDTH (TAB_W),
		.DEPTH (SINE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (SINE_TABLE[fill_q]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register loads when it is empty or being taken
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			fill_q      <= '0;
			run_q       <= 1'b0;
			t1_q        <= '0;
			res_q       <= '0;
			sample_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == IDX_W'(SINE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						run_q   <= lane_cmd.run;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (idle1 && idle2) begin
						if (run_q) begin
							state_q <= S_RD1;
						end else begin
							res_q   <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_RD1: begin
					t1_q    <= tab_rd;
					state_q <= S_RD2;
				end
				S_RD2: begin
					res_q   <= SAMPLE_W'(t1_q) + SAMPLE_W'(tab_rd);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						sample_q <= res_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

`default_nettype wire

// File: rtl/dtsg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dtsg_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/dtsg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dtsg_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dtsg_pkg::div_cmd_t            cmd,
	input  wire logic [dtsg_pkg::RATE_W-1:0]   numer,
	input  wire logic [dtsg_pkg::RATE_W-1:0]   rem_init,
	input  wire logic [dtsg_pkg::RATE_W-1:0]   denom,
	output logic                               busy,
	output logic      [dtsg_pkg::RATE_W-1:0]   quo,
	output logic      [dtsg_pkg::RATE_W-1:0]   rem
);

	import dtsg_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0] num_q;
	logic [RATE_W-1:0] quo_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W:0]   trial;
	logic [RATE_W:0]   diff;
	logic              fits;

	// one restoring step: bring down the next dividend bit
	assign trial = {rem_q, num_q[RATE_W-1]};
	assign diff  = trial - {1'b0, denom};
	assign fits  = trial >= {1'b0, denom};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend, quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= numer;
			rem_q <= rem_init;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[RATE_W-2:0], 1'b0};
			quo_q <= {quo_q[RATE_W-2:0], fits};
			rem_q <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// File: rtl/dtsg_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dtsg_lane #(
	parameter int SINE_ENTRIES = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dtsg_pkg::lane_cmd_t                cmd,
	input  wire logic [dtsg_pkg::FREQ_W-1:0]        freq,
	input  wire logic [dtsg_pkg::RATE_W-1:0]        rate,
	output logic                                    idle,
	output logic      [$clog2(SINE_ENTRIES)-1:0]    idx
);

	import dtsg_pkg::*;

	localparam int IDX_W  = $clog2(SINE_ENTRIES);
	localparam int PROD_W = RATE_W + $clog2(SINE_ENTRIES + 1);

	typedef enum logic [2:0] {
		L_IDLE,
		L_PMOD,
		L_MUL,
		L_QSTART,
		L_IDX,
		L_FMOD,
		L_ADV
	} state_t;

	state_t            state_q;
	logic [RATE_W-1:0] phase_q;
	logic [RATE_W-1:0] work_q;
	logic [RATE_W-1:0] fr_q;
	logic [FREQ_W-1:0] freq_q;
	logic [PROD_W-1:0] prod_q;
	logic [IDX_W-1:0]  idx_q;

	logic [RATE_W-1:0] ph_in;
	logic              ph_ge;
	logic              freq_ge;
	logic [RATE_W:0]   adv_sum;
	logic              adv_wrap;

	div_cmd_t          div_cmd;
	logic [RATE_W-1:0] div_num;
	logic [RATE_W-1:0] div_rem_init;
	logic              div_busy;
	logic [RATE_W-1:0] div_quo;
	logic [RATE_W-1:0] div_rem;

	// phase seen by this sample, after an optional segment restart
	assign ph_in    = cmd.clear ? '0 : phase_q;
	assign ph_ge    = ph_in >= rate;
	assign freq_ge  = {1'b0, freq_q} >= rate;
	assign adv_sum  = {1'b0, work_q} + {1'b0, fr_q};
	assign adv_wrap = adv_sum >= {1'b0, rate};

	// divider requests: phase reduction, table index, frequency reduction
	always_comb begin
		div_cmd      = '0;
		div_num      = '0;
		div_rem_init = '0;
		case (state_q)
			L_IDLE: begin
				div_cmd.start = cmd.start && cmd.run && ph_ge;
				div_cmd.steps = CNT_W'(RATE_W);
				div_num       = ph_in;
			end
			L_QSTART: begin
				div_cmd.start = 1'b1;
				div_cmd.steps = CNT_W'(IDX_W);
				div_num       = RATE_W'(prod_q[IDX_W-1:0]) << (RATE_W - IDX_W);
				div_rem_init  = RATE_W'(prod_q >> IDX_W);
			end
			L_IDX: begin
				div_cmd.start = !div_busy && freq_ge;
				div_cmd.steps = CNT_W'(FREQ_W);
				div_num       = RATE_W'(freq_q) << (RATE_W - FREQ_W);
			end
			default: begin
			end
		endcase
	end

	dtsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.numer    (div_num),
		.rem_init (div_rem_init),
		.denom    (rate),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// lane sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			phase_q <= '0;
			work_q  <= '0;
			fr_q    <= '0;
			freq_q  <= '0;
			prod_q  <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (cmd.start) begin
						freq_q <= freq;
						if (!cmd.run) begin
							phase_q <= ph_in;
						end else if (ph_ge) begin
							state_q <= L_PMOD;
						end else begin
							work_q  <= ph_in;
							state_q <= L_MUL;
						end
					end
				end
				L_PMOD: begin
					if (!div_busy) begin
						work_q  <= div_rem;
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					prod_q  <= PROD_W'(work_q) * PROD_W'(SINE_ENTRIES);
					state_q <= L_QSTART;
				end
				L_QSTART: begin
					state_q <= L_IDX;
				end
				L_IDX: begin
					if (!div_busy) begin
						idx_q <= div_quo[IDX_W-1:0];
						if (freq_ge) begin
							state_q <= L_FMOD;
						end else begin
							fr_q    <= RATE_W'(freq_q);
							state_q <= L_ADV;
						end
					end
				end
				L_FMOD: begin
					if (!div_busy) begin
						fr_q    <= div_rem;
						state_q <= L_ADV;
					end
				end
				L_ADV: begin
					phase_q <= adv_wrap ? RATE_W'(adv_sum - {1'b0, rate}) : RATE_W'(adv_sum);
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign idle = state_q == L_IDLE;
	assign idx  = idx_q;

endmodule

`default_nettype wire

// File: test/dual_tone_sine_generator_core_tb.sv
`timescale 1ns / 1ps

module dual_tone_sine_generator_core_tb;
	import dtsg_pkg::*;

	localparam int SINE_ENTRIES = 1024;
	localparam int FREQ_MAX     = (1 << FREQ_W) - 1;
	localparam int RATE_MAX     = (1 << RATE_W) - 1;
	localparam int STALL_LIMIT  = 6000;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 80;

	// expected samples from a software copy of both phase accumulators
	class tone_scoreboard;
		logic signed [TAB_W-1:0]    sine_values [SINE_ENTRIES];
		bit [31:0]                  rate;
		bit [31:0]                  first_acc;
		bit [31:0]                  second_acc;
		logic [SAMPLE_W-1:0]        expected_samples [$];
		int                         mismatches;
		int                         checked;
		int                         ticks;

		function new();
			for (int k = 0; k < SINE_ENTRIES; k++)
				sine_values[k] = sine_value(k);
			rate = RATE_RESET;
			first_acc = 0;
			second_acc = 0;
			mismatches = 0;
			checked = 0;
			ticks = 0;
		endfunction

		// (a * b) >> 62 in Q2.62, kept to 64 bits
		function bit [63:0] q62_mul(bit [63:0] a, bit [63:0] b);
			bit [127:0] prod;
			prod = {64'd0, a} * {64'd0, b};
			return prod[125:62];
		endfunction

		// trunc(2048 * sin(2 pi k / N)) from an integer Taylor series
		function logic signed [TAB_W-1:0] sine_value(int k);
			bit [63:0] n, twelve, quad, q, rem, x, x2, term, acc_sum;
			int        mag;
			n = SINE_ENTRIES;
			twelve = 12 * k;
			if (twelve % n == 0)
				return EXACT_TWELFTHS[(twelve / n) % 12];
			quad = 4 * k;
			q = quad / n;
			rem = quad % n;
			if (q[0])
				rem = n - rem;
			x = (HALF_PI_Q62 / n) * rem + ((HALF_PI_Q62 % n) * rem) / n;
			x2 = q62_mul(x, x);
			term = x;
			acc_sum = x;
			for (int i = 1; i <= 20; i++) begin
				term = q62_mul(term, x2) / ((2 * i) * (2 * i + 1));
				if (i % 2)
					acc_sum = acc_sum - term;
				else
					acc_sum = acc_sum + term;
			end
			mag = int'(acc_sum >> 51);
			return (q >= 2) ? TAB_W'(-mag) : TAB_W'(mag);
		endfunction

		function int tone_level(bit [31:0] phase);
			bit [63:0] idx;
			idx = (64'(phase) * SINE_ENTRIES) / 64'(rate);
			if (idx >= SINE_ENTRIES)
				idx = SINE_ENTRIES - 1;
			return sine_values[idx];
		endfunction

		function void set_rate(bit [RATE_W-1:0] value);
			rate = value;
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		// one accepted sample request
		function void note_tick(bit [FREQ_W-1:0] f1, bit [FREQ_W-1:0] f2, bit restart);
			int level;
			level = 0;
			ticks++;
			if (restart) begin
				first_acc = 0;
				second_acc = 0;
			end
			if (rate != 0) begin
				first_acc = first_acc % rate;
				second_acc = second_acc % rate;
				level = tone_level(first_acc) + tone_level(second_acc);
				first_acc = (first_acc + f1 % rate) % rate;
				second_acc = (second_acc + f2 % rate) % rate;
			end
			expected_samples.push_back(SAMPLE_W'(level));
		endfunction

		function void report(string what, logic [SAMPLE_W-1:0] want,
				logic [SAMPLE_W-1:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s: expected sample %0d, got %0d", $realtime, what,
					$signed(want), $signed(got));
		endfunction

		// one accepted result
		function void check_sample(logic [SAMPLE_W-1:0] got);
			logic [SAMPLE_W-1:0] want;
			if (expected_samples.size() == 0) begin
				report("sample with no request outstanding", 'x, got);
				return;
			end
			want = expected_samples.pop_front();
			checked++;
			if (got !== want)
				report("sample mismatch", want, got);
		endfunction

		function void close_out();
			if (expected_samples.size() != 0) begin
				mismatches += expected_samples.size();
				$display("%0d expected samples never arrived", expected_samples.size());
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [RATE_W-1:0]          rate_hz;
	logic                       in_valid;
	logic                       in_stall;
	logic [FREQ_W-1:0]          first_frequency;
	logic [FREQ_W-1:0]          second_frequency;
	logic                       segment_start;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] sample;

	tone_scoreboard sb;
	bit             idle_on;
	bit             hold_output_long;
	int             idle_cycles;
	int             rate_writes;
	int             input_stalls;

	dual_tone_sine_generator_core #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.rate_hz(rate_hz),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_frequency(first_frequency),
		.second_frequency(second_frequency),
		.segment_start(segment_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// monitor: prediction, checking and the progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.set_rate(rate_hz);
				rate_writes++;
			end
			if (in_valid && in_stall)
				input_stalls++;
			if (in_valid && !in_stall)
				sb.note_tick(first_frequency, second_frequency, segment_start);
			if (out_valid && !out_stall)
				sb.check_sample(sample);
		end
		if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("timeout: no progress for %0d cycles", STALL_LIMIT);
			$display("FAIL dual_tone_sine_generator_core");
			$finish;
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int wait_n;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_output_long) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_output_long = 1'b0;
			end
			wait_n = idle_on ? $urandom_range(0, 6) : 0;
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// send one sample request and wait until it is taken
	task automatic send_tick(input bit [FREQ_W-1:0] f1, input bit [FREQ_W-1:0] f2,
			input bit restart);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		first_frequency <= f1;
		second_frequency <= f2;
		segment_start <= restart;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait for every outstanding sample
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// rate change, only with the block idle
	task automatic write_rate(input bit [RATE_W-1:0] value);
		drain();
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		rate_hz <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit [FREQ_W-1:0] pick_frequency();
		int roll;
		int top;
		roll = $urandom_range(0, 19);
		top = (sb.rate == 0 || sb.rate - 1 > FREQ_MAX) ? FREQ_MAX : sb.rate - 1;
		if (roll < 2)
			return '0;
		if (roll < 5)
			return FREQ_W'($urandom_range(0, FREQ_MAX));
		if (roll == 5)
			return FREQ_W'(top);
		return FREQ_W'($urandom_range(0, top));
	endfunction

	// mostly long segments with random tones, some restarts
	task automatic random_ticks(input int count);
		bit restart;
		for (int i = 0; i < count; i++) begin
			restart = ($urandom_range(0, 99) < 4);
			send_tick(pick_frequency(), pick_frequency(), restart);
		end
	endtask

	initial begin
		sb = new();
		idle_on = 1'b0;
		hold_output_long = 1'b0;
		idle_cycles = 0;
		rate_writes = 0;
		input_stalls = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		rate_hz = '0;
		in_valid = 1'b0;
		first_frequency = '0;
		second_frequency = '0;
		segment_start = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset rate: quarter and twelfth phases, edge frequencies, restarts
		send_tick(0, 0, 1);
		send_tick(12000, 0, 0);
		send_tick(12000, 12000, 0);
		send_tick(0, 0, 0);
		send_tick(FREQ_MAX, FREQ_MAX, 0);
		send_tick(47999, 96000, 0);
		send_tick(48000, 1, 0);
		send_tick(65536, 32768, 1);
		send_tick(4000, 8000, 0);
		send_tick(4000, 8000, 0);
		send_tick(1, 95999, 0);
		send_tick(0, 0, 0);
		idle_on = 1'b1;
		random_ticks(240);

		// high rate, receiver held off long enough to back up the input
		write_rate(192000);
		hold_output_long = 1'b1;
		random_ticks(200);

		// rate lowered in the middle of a segment, no idling after the change
		write_rate(8000);
		idle_on = 1'b0;
		send_tick(0, 0, 0);
		random_ticks(190);

		// silent rate: phases held, restart still clears them
		write_rate(0);
		idle_on = 1'b1;
		send_tick(5000, 7000, 0);
		send_tick(FREQ_MAX, FREQ_MAX, 1);
		send_tick(100, 100, 0);
		random_ticks(60);

		// held phases meet a nonzero rate again
		write_rate(1);
		random_ticks(60);
		write_rate(RATE_MAX);
		random_ticks(150);
		drain();
		write_rate(44100);
		random_ticks(200);
		write_rate(1000);
		idle_on = 1'b0;
		random_ticks(150);
		write_rate(96000);
		idle_on = 1'b1;
		random_ticks(180);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();

		$display("covered %0d requests and %0d checked samples over %0d rate writes,",
			sb.ticks, sb.checked, rate_writes);
		$display("rates 0 to %0d, with %0d cycles of input back-pressure", RATE_MAX,
			input_stalls);
		if (sb.mismatches == 0) begin
			$display("PASS dual_tone_sine_generator_core");
		end else begin
			$display("%0d failures", sb.mismatches);
			$display("FAIL dual_tone_sine_generator_core");
		end
		$finish;
	end

endmodule
